>>> src/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define BNB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define BNB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Condition that must hold on the cycle after reset is applied.
`define BNB_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("reset check failed");

`endif

>>> src/bnb_pkg.sv
package bnb_pkg;

  // Fixed field widths of the item channels
  localparam int OP_W    = 2;
  localparam int CLASS_W = 4;
  localparam int PIX_W   = 10;
  localparam int LOAD_W  = 16;
  localparam int SCORE_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_WEIGHTS = 2'd0,
    OP_LOAD_PRIOR   = 2'd1,
    OP_CLASSIFY     = 2'd2
  } op_t;

  typedef enum logic {
    ST_RUN,
    ST_SCAN
  } state_t;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

endpackage

>>> src/bnb_in_if.sv
interface bnb_in_if;
  logic                               valid;
  logic                               ready;
  logic [bnb_pkg::OP_W-1:0]           operation;
  logic [bnb_pkg::CLASS_W-1:0]        class_index;
  logic [bnb_pkg::PIX_W-1:0]          pixel_index;
  logic signed [bnb_pkg::LOAD_W-1:0]  weight_white;
  logic signed [bnb_pkg::LOAD_W-1:0]  weight_black;
  logic                               pixel_bit;
  logic                               last_pixel;

  modport source (
    output valid, operation, class_index, pixel_index, weight_white, weight_black,
           pixel_bit, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, operation, class_index, pixel_index, weight_white, weight_black,
           pixel_bit, last_pixel,
    output ready
  );
endinterface

>>> src/bnb_out_if.sv
interface bnb_out_if;
  logic                               valid;
  logic                               ready;
  logic [bnb_pkg::CLASS_W-1:0]        predicted_class;
  logic signed [bnb_pkg::SCORE_W-1:0] best_score;

  modport source (
    output valid, predicted_class, best_score,
    input  ready
  );

  modport sink (
    input  valid, predicted_class, best_score,
    output ready
  );
endinterface

>>> src/bnb_ram.sv
module bnb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 784
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/bernoulli_naive_bayes_classifier.sv
// Bernoulli naive Bayes classifier for binarized images.
// Channel sample carries three kinds of item, chosen by operation: a weight
// load (white and black log weights for one class and pixel), a prior load
// (weight_white holds the class prior) and a classify item for one pixel.
// Loads and classify items are taken one per cycle while intake is open. Each
// class has its own weight memory, read at the pixel address into a register,
// so a pixel's weights are then added to all class scores in the score
// registers. The first classify item of an image starts every score from its
// prior; scores saturate to 32 bits. On the item marked last_pixel, intake
// stops while a scan visits the class scores one per cycle. The result
// becomes valid on channel result when the scan ends, and intake reopens in
// that same cycle.
// The result waits in an output register; while the receiver stalls, a
// finished scan holds and the block takes no item, otherwise loads and
// pixels keep flowing past a waiting result.
// Reset clears the scores, the image flag, the scan and the output register;
// weight memories and priors are undefined until loaded.
module bernoulli_naive_bayes_classifier #(
  parameter int NUM_PIXELS  = 784,
  parameter int NUM_CLASSES = 10,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  bnb_in_if.sink      sample,
  bnb_out_if.source   result
);

  localparam int PIX_AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int WB     = WEIGHT_BITS;
  localparam int SW     = bnb_pkg::SCORE_W;

  logic accept;
  logic class_ok, pix_ok;
  logic is_load_w, is_load_p, is_classify;
  logic [PIX_AW-1:0] pix_addr;
  logic signed [WB-1:0] white_w, black_w;

  logic [2*WB-1:0] rd_data [NUM_CLASSES];
  logic signed [WB-1:0] prior [NUM_CLASSES];
  logic signed [SW-1:0] scores [NUM_CLASSES];
  logic signed [SW-1:0] scores_next [NUM_CLASSES];

  logic image_active;
  logic s1_valid, s1_first, s1_pix_ok, s1_bit, s1_last;

  bnb_pkg::state_t state, state_next;
  logic [CLS_W-1:0] scan_idx;
  logic [CLS_W-1:0] best_idx;
  logic signed [SW-1:0] best_val;
  logic [CLS_W-1:0] cand_idx;
  logic signed [SW-1:0] cand_val;
  logic scan_end, out_free, out_load, scan_start;

  logic out_valid;
  logic [CLS_W-1:0] out_class;
  logic signed [SW-1:0] out_score;

  // Decode the incoming item
  assign accept      = sample.valid && sample.ready;
  assign class_ok    = 32'(sample.class_index) < NUM_CLASSES;
  assign pix_ok      = 32'(sample.pixel_index) < NUM_PIXELS;
  assign is_load_w   = accept && (sample.operation == bnb_pkg::OP_LOAD_WEIGHTS);
  assign is_load_p   = accept && (sample.operation == bnb_pkg::OP_LOAD_PRIOR);
  assign is_classify = accept && (sample.operation == bnb_pkg::OP_CLASSIFY);
  assign pix_addr    = PIX_AW'(sample.pixel_index);

  // Fit loaded values to the stored weight width
  if (WB <= bnb_pkg::LOAD_W) begin : g_wrap
    assign white_w = sample.weight_white[WB-1:0];
    assign black_w = sample.weight_black[WB-1:0];
  end else begin : g_sext
    assign white_w = WB'(sample.weight_white);
    assign black_w = WB'(sample.weight_black);
  end

  // One weight memory per class, white and black side by side
  for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_class
    logic we;
    assign we = is_load_w && class_ok && pix_ok && (32'(sample.class_index) == k);

    bnb_ram #(
      .WIDTH (2 * WB),
      .DEPTH (NUM_PIXELS)
    ) u_weights (
      .clk   (clk),
      .we    (we),
      .waddr (pix_addr),
      .wdata ({white_w, black_w}),
      .re    (is_classify && pix_ok),
      .raddr (pix_addr),
      .rdata (rd_data[k])
    );

    // Hold the class prior
    always_ff @(posedge clk) begin
      if (is_load_p && class_ok && (32'(sample.class_index) == k)) begin
        prior[k] <= white_w;
      end
    end
  end

  // Track image boundaries and stage the pixel for the read-back cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      image_active <= 1'b0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= is_classify;
      if (is_classify) begin
        image_active <= !sample.last_pixel;
      end
    end
    if (is_classify) begin
      s1_first  <= !image_active;
      s1_pix_ok <= pix_ok;
      s1_bit    <= sample.pixel_bit;
      s1_last   <= sample.last_pixel;
    end
  end

  // Add the selected weight to every class score, saturating; an out-of-range pixel adds nothing
  always_comb begin
    logic signed [WB-1:0]   w_sel;
    logic signed [SW-1:0]   base;
    logic signed [SW:0]     sum;
    logic signed [SW-1:0]   sat;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      w_sel = s1_bit ? rd_data[k][2*WB-1:WB] : rd_data[k][WB-1:0];
      base  = s1_first ? SW'(prior[k]) : scores[k];
      sum   = (SW+1)'(base) + (SW+1)'(w_sel);
      if (sum[SW] != sum[SW-1]) begin
        sat = sum[SW] ? bnb_pkg::SCORE_MIN : bnb_pkg::SCORE_MAX;
      end else begin
        sat = sum[SW-1:0];
      end
      scores_next[k] = s1_pix_ok ? sat : base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        scores[k] <= '0;
      end
    end else if (s1_valid) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        scores[k] <= scores_next[k];
      end
    end
  end

  // Scan candidate: strictly greater wins, so the lowest index keeps ties
  always_comb begin
    if ((scan_idx == '0) || (scores[scan_idx] > best_val)) begin
      cand_idx = scan_idx;
      cand_val = scores[scan_idx];
    end else begin
      cand_idx = best_idx;
      cand_val = best_val;
    end
  end

  assign scan_end   = (scan_idx == CLS_W'(NUM_CLASSES - 1));
  assign out_free   = !out_valid || result.ready;
  assign scan_start = s1_valid && s1_last;

  // Next state and control outputs
  always_comb begin
    state_next   = state;
    out_load     = 1'b0;
    sample.ready = 1'b0;
    case (state)
      bnb_pkg::ST_RUN: begin
        sample.ready = !scan_start;
        if (scan_start) begin
          state_next = bnb_pkg::ST_SCAN;
        end
      end
      bnb_pkg::ST_SCAN: begin
        if (scan_end && out_free) begin
          out_load   = 1'b1;
          state_next = bnb_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = bnb_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bnb_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Advance the scan one class per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (scan_start) begin
      scan_idx <= '0;
    end else if ((state == bnb_pkg::ST_SCAN) && !scan_end) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if ((state == bnb_pkg::ST_SCAN) && !scan_end) begin
      best_idx <= cand_idx;
      best_val <= cand_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_class <= cand_idx;
      out_score <= cand_val;
    end
  end

  assign result.valid           = out_valid;
  assign result.predicted_class = bnb_pkg::CLASS_W'(out_class);
  assign result.best_score      = out_score;

endmodule

>>> src/bnb_checker.sv
`include "assert_macros.svh"

module bnb_checker #(
  parameter int NUM_CLASSES = 10
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [bnb_pkg::OP_W-1:0]           in_operation,
  input logic                               in_last_pixel,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [bnb_pkg::CLASS_W-1:0]        predicted_class,
  input logic signed [bnb_pkg::SCORE_W-1:0] best_score
);

  logic last_taken;
  logic [bnb_pkg::CLASS_W+bnb_pkg::SCORE_W-1:0] out_payload;
  assign last_taken = in_valid && in_ready && in_last_pixel &&
                      (in_operation == bnb_pkg::OP_CLASSIFY);
  assign out_payload = {predicted_class, best_score};

  // A stalled result keeps its value
  `BNB_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // The winner is always a real class
  `BNB_ASSERT_IMP(a_class_range, out_valid, 32'(predicted_class) < NUM_CLASSES)

  // Intake closes right after the last pixel of an image
  `BNB_ASSERT_NXT(a_busy_after_last, last_taken, !in_ready)

  // Reset empties the output register
  `BNB_ASSERT_RST(a_reset_empty, !out_valid)

endmodule

bind bernoulli_naive_bayes_classifier bnb_checker #(
  .NUM_CLASSES (NUM_CLASSES)
) u_bnb_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (sample.valid),
  .in_ready        (sample.ready),
  .in_operation    (sample.operation),
  .in_last_pixel   (sample.last_pixel),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .predicted_class (result.predicted_class),
  .best_score      (result.best_score)
);
